/* rtl/ppab_pkg.sv */
// Shared constants, request codes and controller/datapath command types for the sample buffer.
package ppab_pkg;

   localparam int unsigned HALF_DEPTH  = 256;
   localparam int unsigned STORE_DEPTH = 2 * HALF_DEPTH;
   localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);

   localparam int unsigned SAMPLE_W   = 8;
   localparam int unsigned INDEX_W    = 9;
   localparam int unsigned KIND_W     = 2;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [ADDR_W-1:0] HALF_POS  = ADDR_W'(HALF_DEPTH);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);
   localparam logic [ADDR_W:0]   HALF_EXT  = (ADDR_W + 1)'(HALF_DEPTH);
   localparam logic [ADDR_W:0]   STORE_EXT = (ADDR_W + 1)'(STORE_DEPTH);

   // register index as decoded from paddr[2]
   localparam logic CSR_IDX_MONO = 1'b0;

   typedef enum logic [KIND_W-1:0] {
      REQ_WRITE   = 2'd0,
      REQ_TICK    = 2'd1,
      REQ_ACK     = 2'd2,
      REQ_RESTART = 2'd3
   } req_kind_type;

   typedef struct packed {
      logic take;         // request transaction accepted this cycle
      logic load_direct;  // load output register with a non-tick result
      logic load_tick;    // load output register from the store read data
   } ppab_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic req_is_tick;
      logic out_full;
      logic rsp_ready;
   } ppab_sts_type;

endpackage

/* rtl/ppab_req_if.sv */
// Request channel: valid/ready handshake plus request payload.
interface ppab_req_if import ppab_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   req_type;
   logic [INDEX_W-1:0]  write_index;
   logic [SAMPLE_W-1:0] write_byte;
   logic                ack_half;

   modport source (output valid, req_type, write_index, write_byte, ack_half, input ready);
   modport sink   (input valid, req_type, write_index, write_byte, ack_half, output ready);
endinterface

/* rtl/ppab_rsp_if.sv */
// Response channel: valid/ready handshake plus sample and flag payload.
interface ppab_rsp_if import ppab_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] left_duty;
   logic [SAMPLE_W-1:0] right_duty;
   logic                sample_valid;
   logic                low_half_empty;
   logic                high_half_empty;

   modport source (output valid, left_duty, right_duty, sample_valid, low_half_empty,
                   high_half_empty, input ready);
   modport sink   (input valid, left_duty, right_duty, sample_valid, low_half_empty,
                   high_half_empty, output ready);
endinterface

/* rtl/ping_pong_audio_sample_buffer_core.sv */
// Top level of the ping-pong audio sample buffer: channels, CSR port and submodules.
//
// Usage:
//   req_ch carries one request per transaction: write a byte to the store, play a
//   sample tick, acknowledge a refilled half, or restart playback. rsp_ch returns
//   exactly one response per request with the duty pair (ticks only) and both
//   half-empty flags as they stand after the request.
//   The APB port holds mono_mode at byte address 0; write it only while idle.
// Timing:
//   Writes, acknowledges and restarts: response valid in the cycle after acceptance,
//   one request per cycle while responses are taken. Sample ticks: the store read is
//   registered, then S_READ loads the output register once free; nothing is accepted in S_READ.
//   A request is accepted in the same cycle a waiting response is taken.
// Reset (synchronous, active high): read position 0, both flags clear, stereo
//   mode, no response pending. Store contents are not cleared; entries must be
//   written before they are played.
// Backpressure: while rsp_ch.ready is low a pending response holds and req_ch
//   accepts nothing while the output register holds a response not being taken.
module ping_pong_audio_sample_buffer_core import ppab_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   ppab_req_if.sink              req_ch,
   ppab_rsp_if.source            rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   ppab_cmd_type cmd;
   ppab_sts_type sts;
   logic         mono_we;
   logic         mono_mode;
   logic         csr_hit_mono;

   assign pready       = 1'b1;
   assign csr_hit_mono = (paddr[2] == CSR_IDX_MONO);
   assign mono_we      = psel && penable && pwrite && pready && csr_hit_mono;
   assign prdata       = csr_hit_mono ? {{(CSR_DATA_W - 1){1'b0}}, mono_mode} : '0;

   ppab_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .sts       (sts),
      .cmd       (cmd),
      .req_ready (req_ch.ready)
   );

   ppab_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_valid       (req_ch.valid),
      .req_type        (req_ch.req_type),
      .write_index     (req_ch.write_index),
      .write_byte      (req_ch.write_byte),
      .ack_half        (req_ch.ack_half),
      .rsp_ready       (rsp_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .left_duty       (rsp_ch.left_duty),
      .right_duty      (rsp_ch.right_duty),
      .sample_valid    (rsp_ch.sample_valid),
      .low_half_empty  (rsp_ch.low_half_empty),
      .high_half_empty (rsp_ch.high_half_empty),
      .mono_we         (mono_we),
      .mono_wd         (pwdata[0]),
      .mono_mode       (mono_mode)
   );

endmodule

/* rtl/ppab_ram.sv */
// Generic RAM: one write port, two registered read ports sharing a read enable.
module ppab_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

/* rtl/ppab_ctrl.sv */
// Controller state machine: request acceptance and output register loading.
module ppab_ctrl import ppab_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  ppab_sts_type sts,
   output ppab_cmd_type cmd,
   output logic         req_ready
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_READ = 2'b10
   } ctrl_state_type;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           out_free;

   // output register is free if empty or being drained this cycle
   assign out_free = !sts.out_full || sts.rsp_ready;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = out_free;
            if (sts.req_valid && out_free) begin
               cmd.take = 1'b1;
               if (sts.req_is_tick) begin
                  state_in = S_READ;
               end else begin
                  cmd.load_direct = 1'b1;
               end
            end
         end
         S_READ: begin
            if (out_free) begin
               cmd.load_tick = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_no_accept_in_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |-> !req_ready)
      else $error("request accepted while a tick read is pending");

   a_tick_goes_read: assert property (@(posedge clock) disable iff (reset)
      cmd.take && sts.req_is_tick |=> state_ff == S_READ)
      else $error("tick transaction did not start a store read");

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_direct || cmd.load_tick) |-> out_free)
      else $error("output register overwritten before it was taken");
`endif

endmodule

/* rtl/ppab_dp.sv */
// Datapath: sample store, read position, empty flags, mode register and output register.
module ppab_dp import ppab_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  ppab_cmd_type        cmd,
   output ppab_sts_type        sts,
   input  logic                req_valid,
   input  logic [KIND_W-1:0]   req_type,
   input  logic [INDEX_W-1:0]  write_index,
   input  logic [SAMPLE_W-1:0] write_byte,
   input  logic                ack_half,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [SAMPLE_W-1:0] left_duty,
   output logic [SAMPLE_W-1:0] right_duty,
   output logic                sample_valid,
   output logic                low_half_empty,
   output logic                high_half_empty,
   input  logic                mono_we,
   input  logic                mono_wd,
   output logic                mono_mode
);

   req_kind_type        kind;
   logic [ADDR_W-1:0]   pos_ff, pos_in;
   logic                low_ff, low_in;
   logic                high_ff, high_in;
   logic                mono_ff, mono_in;
   logic                out_valid_ff, out_valid_in;
   logic [SAMPLE_W-1:0] left_ff, left_in;
   logic [SAMPLE_W-1:0] right_ff, right_in;
   logic                sv_ff, sv_in;
   logic                low_out_ff, low_out_in;
   logic                high_out_ff, high_out_in;
   logic [ADDR_W:0]     step_sum;
   logic [ADDR_W-1:0]   pair_addr;
   logic                ram_we;
   logic                ram_re;
   logic [SAMPLE_W-1:0] rd_a;
   logic [SAMPLE_W-1:0] rd_b;

   assign kind = req_kind_type'(req_type);

   assign step_sum  = {1'b0, pos_ff} + (mono_ff ? (ADDR_W + 1)'(1) : (ADDR_W + 1)'(2));
   // right byte of a stereo pair wraps from the last entry to entry 0
   assign pair_addr = (pos_ff == LAST_ADDR) ? '0 : pos_ff + ADDR_W'(1);

   assign ram_we = cmd.take && (kind == REQ_WRITE) && (32'(write_index) < STORE_DEPTH);
   assign ram_re = cmd.take && (kind == REQ_TICK);

   ppab_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (ADDR_W'(write_index)),
      .wr_data   (write_byte),
      .rd_en     (ram_re),
      .rd_addr_a (pos_ff),
      .rd_addr_b (pair_addr),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   always_comb begin
      pos_in  = pos_ff;
      low_in  = low_ff;
      high_in = high_ff;
      if (cmd.take) begin
         unique case (kind)
            REQ_WRITE: begin
            end
            REQ_TICK: begin
               if (pos_ff < HALF_POS && step_sum >= HALF_EXT) begin
                  low_in = 1'b1;
               end
               if (step_sum >= STORE_EXT) begin
                  high_in = 1'b1;
                  pos_in  = ADDR_W'(step_sum - STORE_EXT);
               end else begin
                  pos_in = step_sum[ADDR_W-1:0];
               end
            end
            REQ_ACK: begin
               if (ack_half) begin
                  high_in = 1'b0;
               end else begin
                  low_in = 1'b0;
               end
            end
            REQ_RESTART: begin
               pos_in  = '0;
               low_in  = 1'b0;
               high_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   assign mono_in = mono_we ? mono_wd : mono_ff;

   always_comb begin
      left_in     = left_ff;
      right_in    = right_ff;
      sv_in       = sv_ff;
      low_out_in  = low_out_ff;
      high_out_in = high_out_ff;
      if (cmd.load_direct) begin
         left_in     = '0;
         right_in    = '0;
         sv_in       = 1'b0;
         low_out_in  = low_in;
         high_out_in = high_in;
      end else if (cmd.load_tick) begin
         // flags were already advanced when the tick was accepted
         left_in     = rd_a;
         right_in    = mono_ff ? rd_a : rd_b;
         sv_in       = 1'b1;
         low_out_in  = low_ff;
         high_out_in = high_ff;
      end
   end

   always_comb begin
      priority if (cmd.load_direct || cmd.load_tick) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         low_ff       <= 1'b0;
         high_ff      <= 1'b0;
         mono_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         mono_ff      <= mono_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff     <= left_in;
      right_ff    <= right_in;
      sv_ff       <= sv_in;
      low_out_ff  <= low_out_in;
      high_out_ff <= high_out_in;
   end

   assign sts.req_valid   = req_valid;
   assign sts.req_is_tick = (kind == REQ_TICK);
   assign sts.out_full    = out_valid_ff;
   assign sts.rsp_ready   = rsp_ready;

   assign rsp_valid       = out_valid_ff;
   assign left_duty       = left_ff;
   assign right_duty      = right_ff;
   assign sample_valid    = sv_ff;
   assign low_half_empty  = low_out_ff;
   assign high_half_empty = high_out_ff;
   assign mono_mode       = mono_ff;

`ifndef SYNTHESIS
   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.take && kind == REQ_RESTART |=> pos_ff == '0 && !low_ff && !high_ff)
      else $error("restart did not clear position and flags");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |=> out_valid_ff)
      else $error("pending response transaction dropped");

   a_direct_no_sample: assert property (@(posedge clock) disable iff (reset)
      cmd.load_direct |=> !sv_ff)
      else $error("non-tick response transaction marked as a sample");
`endif

endmodule
